FILE: design/page_table_entry_builder_assert.svh
// Assertion macros used by the checker of the page table entry builder.
`ifndef PAGE_TABLE_ENTRY_BUILDER_ASSERT_SVH
`define PAGE_TABLE_ENTRY_BUILDER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTEB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pteb_pkg.sv
package pteb_pkg;

    localparam int ADDR_W        = 32;
    localparam int L1_IDX_W      = 12;
    localparam int L2_IDX_W      = 8;
    localparam int PAGE_FRAME_W  = 20;
    localparam int COARSE_HI_W   = 22;
    localparam int DOMAIN_W      = 4;
    localparam int AP_W          = 2;
    localparam int CB_W          = 2;
    localparam int L1_ENTRIES    = 4096;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [L1_IDX_W-1:0] L1_LAST_IDX = L1_IDX_W'(L1_ENTRIES - 1);

    // 16KB step from the raw start to the coarse table area, in 1KB units.
    localparam logic [COARSE_HI_W-1:0] COARSE_OFFSET = COARSE_HI_W'(16);

    // Descriptor type codes in bits 1:0.
    localparam logic [1:0] DESC_COARSE  = 2'b01;
    localparam logic [1:0] DESC_SECTION = 2'b10;
    localparam logic [1:0] DESC_SMALL   = 2'b10;

    // Contents of the first-level type store.
    localparam logic L1_IS_COARSE  = 1'b1;
    localparam logic L1_NOT_COARSE = 1'b0;

    typedef struct packed {
        logic                    is_page;
        logic [L1_IDX_W-1:0]     l1_idx;
        logic [L2_IDX_W-1:0]     l2_idx;
        logic [PAGE_FRAME_W-1:0] frame;
        logic [DOMAIN_W-1:0]     domain;
        logic [AP_W-1:0]         ap;
        logic [CB_W-1:0]         cb;
    } map_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic clear_done;
    } back_status_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOKUP,
        B_EMIT_TABLE,
        B_EMIT_LAST
    } back_state_t;

endpackage

FILE: design/pteb_queue.sv
module pteb_queue #(
    parameter int DEPTH = pteb_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pteb_pkg::map_entry_t   push_entry,
    input  logic                   pop,
    output pteb_pkg::map_entry_t   head,
    output pteb_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pteb_pkg::map_entry_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = entries[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

FILE: design/pteb_front.sv
module pteb_front (
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [pteb_pkg::ADDR_W-1:0]     virt_addr,
    input  logic [pteb_pkg::ADDR_W-1:0]     phys_addr,
    input  logic [pteb_pkg::DOMAIN_W-1:0]   domain,
    input  logic [pteb_pkg::AP_W-1:0]       access_perm,
    input  logic [pteb_pkg::CB_W-1:0]       cache_buffer,
    input  pteb_pkg::queue_status_t         q_status,
    input  pteb_pkg::back_status_t          b_status,
    output logic                            push,
    output pteb_pkg::map_entry_t            push_entry
);

    // Requests are held off until the type store has been cleared.
    assign in_ready = !q_status.full && b_status.clear_done;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_entry.is_page = kind;
        push_entry.l1_idx  = virt_addr[31:20];
        push_entry.l2_idx  = virt_addr[19:12];
        push_entry.frame   = phys_addr[31:12];
        push_entry.domain  = domain;
        push_entry.ap      = access_perm;
        push_entry.cb      = cache_buffer;
    end

endmodule

FILE: design/pteb_back.sv
module pteb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pteb_pkg::ADDR_W-1:0]     table_start,
    input  pteb_pkg::queue_status_t         q_status,
    input  pteb_pkg::map_entry_t            head,
    output logic                            pop,
    output pteb_pkg::back_status_t          b_status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pteb_pkg::ADDR_W-1:0]     write_addr,
    output logic [pteb_pkg::ADDR_W-1:0]     write_data,
    output logic                            last
);

    pteb_pkg::back_state_t state_reg;
    pteb_pkg::back_state_t state_next;
    logic [pteb_pkg::L1_IDX_W-1:0] clr_cnt_reg;
    pteb_pkg::map_entry_t item_reg;
    logic coarse_reg;
    logic type_mem [pteb_pkg::L1_ENTRIES];

    logic out_valid_reg;
    logic [pteb_pkg::ADDR_W-1:0] addr_reg;
    logic [pteb_pkg::ADDR_W-1:0] data_reg;
    logic last_reg;

    logic slot_free;
    logic rd_en;
    logic we;
    logic wr_bit;
    logic [pteb_pkg::L1_IDX_W-1:0] wr_idx;
    logic load_out;
    logic [pteb_pkg::ADDR_W-1:0] load_addr;
    logic [pteb_pkg::ADDR_W-1:0] load_data;
    logic load_last;

    logic [pteb_pkg::COARSE_HI_W-1:0] coarse_hi;
    logic [pteb_pkg::ADDR_W-1:0] l1_addr;
    logic [pteb_pkg::ADDR_W-1:0] coarse_desc;
    logic [pteb_pkg::ADDR_W-1:0] section_desc;
    logic [pteb_pkg::ADDR_W-1:0] page_addr;
    logic [pteb_pkg::ADDR_W-1:0] page_desc;

    assign slot_free = !out_valid_reg || out_ready;

    // The coarse table start and its index offset are both 1KB aligned, so only
    // bits 31:10 take part in the add and the wrap falls out of the width.
    assign coarse_hi = table_start[31:10] + pteb_pkg::COARSE_OFFSET
                       + pteb_pkg::COARSE_HI_W'(item_reg.l1_idx);
    assign l1_addr = {table_start[31:14], item_reg.l1_idx, 2'b00};
    assign coarse_desc = {coarse_hi, 1'b0, item_reg.domain, 1'b1, 2'b00,
                          pteb_pkg::DESC_COARSE};
    assign section_desc = {item_reg.frame[19:8], 8'h00, item_reg.ap, 1'b0,
                           item_reg.domain, 1'b1, item_reg.cb, pteb_pkg::DESC_SECTION};
    assign page_addr = {coarse_hi, item_reg.l2_idx, 2'b00};
    assign page_desc = {item_reg.frame, item_reg.ap, item_reg.ap, item_reg.ap,
                        item_reg.ap, item_reg.cb, pteb_pkg::DESC_SMALL};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pteb_pkg::B_CLEAR:
            begin
                if (clr_cnt_reg == pteb_pkg::L1_LAST_IDX)
                begin
                    state_next = pteb_pkg::B_IDLE;
                end
            end
            pteb_pkg::B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = pteb_pkg::B_LOOKUP;
                end
            end
            pteb_pkg::B_LOOKUP:
            begin
                if (item_reg.is_page && (coarse_reg != pteb_pkg::L1_IS_COARSE))
                begin
                    state_next = pteb_pkg::B_EMIT_TABLE;
                end
                else
                begin
                    state_next = pteb_pkg::B_EMIT_LAST;
                end
            end
            pteb_pkg::B_EMIT_TABLE:
            begin
                if (slot_free)
                begin
                    state_next = pteb_pkg::B_EMIT_LAST;
                end
            end
            pteb_pkg::B_EMIT_LAST:
            begin
                if (slot_free)
                begin
                    state_next = pteb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = pteb_pkg::B_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        we        = 1'b0;
        wr_bit    = pteb_pkg::L1_NOT_COARSE;
        wr_idx    = item_reg.l1_idx;
        load_out  = 1'b0;
        load_addr = l1_addr;
        load_data = section_desc;
        load_last = 1'b1;
        case (state_reg)
            pteb_pkg::B_CLEAR:
            begin
                we     = 1'b1;
                wr_idx = clr_cnt_reg;
            end
            pteb_pkg::B_IDLE:
            begin
                pop   = !q_status.empty;
                rd_en = !q_status.empty;
            end
            pteb_pkg::B_LOOKUP:
            begin
            end
            pteb_pkg::B_EMIT_TABLE:
            begin
                load_out  = slot_free;
                load_data = coarse_desc;
                load_last = 1'b0;
                we        = slot_free;
                wr_bit    = pteb_pkg::L1_IS_COARSE;
            end
            pteb_pkg::B_EMIT_LAST:
            begin
                load_out = slot_free;
                if (item_reg.is_page)
                begin
                    load_addr = page_addr;
                    load_data = page_desc;
                end
                else
                begin
                    we = slot_free;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pteb_pkg::B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pteb_pkg::B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        if (load_out)
        begin
            addr_reg <= load_addr;
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

    // Type store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            type_mem[wr_idx] <= wr_bit;
        end
        if (rd_en)
        begin
            coarse_reg <= type_mem[head.l1_idx];
        end
    end

    assign b_status.clear_done = (state_reg != pteb_pkg::B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign last       = last_reg;

endmodule

FILE: design/page_table_entry_builder.sv
// Builds the page-table writes for one mapping request per input word: a 1MB
// section gives one write, a 4KB small page gives one write, or two when the
// first-level entry does not yet hold a coarse descriptor (the coarse
// descriptor comes first, with last low). A request is taken into a short
// queue; the back end then reads the first-level type store, looks at the
// result and produces each write in turn, holding a write while out_ready is
// low, and pops the next request only after it has loaded the last write of
// the previous one. The type store is a 4096-entry memory with one port each
// for reading and writing; after reset it is cleared one entry per cycle, and
// while it is being cleared in_ready stays low, while configuration writes are
// still taken. table_start should be written only while no request is in
// flight; the type store keeps its contents across such writes.
module page_table_entry_builder #(
    parameter int QUEUE_DEPTH = pteb_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pteb_pkg::ADDR_W-1:0]     table_start,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [pteb_pkg::ADDR_W-1:0]     virt_addr,
    input  logic [pteb_pkg::ADDR_W-1:0]     phys_addr,
    input  logic [pteb_pkg::DOMAIN_W-1:0]   domain,
    input  logic [pteb_pkg::AP_W-1:0]       access_perm,
    input  logic [pteb_pkg::CB_W-1:0]       cache_buffer,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pteb_pkg::ADDR_W-1:0]     write_addr,
    output logic [pteb_pkg::ADDR_W-1:0]     write_data,
    output logic                            last
);

    logic [pteb_pkg::ADDR_W-1:0] table_start_reg;
    logic push;
    logic pop;
    pteb_pkg::map_entry_t push_entry;
    pteb_pkg::map_entry_t head;
    pteb_pkg::queue_status_t q_status;
    pteb_pkg::back_status_t b_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_start_reg <= table_start;
        end
    end

    pteb_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .domain       (domain),
        .access_perm  (access_perm),
        .cache_buffer (cache_buffer),
        .q_status     (q_status),
        .b_status     (b_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    pteb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    pteb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_start (table_start_reg),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .b_status    (b_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .write_addr  (write_addr),
        .write_data  (write_data),
        .last        (last)
    );

endmodule

FILE: design/pteb_checker.sv
`include "page_table_entry_builder_assert.svh"

module pteb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pteb_pkg::ADDR_W-1:0] write_addr,
    input logic [pteb_pkg::ADDR_W-1:0] write_data,
    input logic                        last
);

    // A stalled write word keeps its contents.
    `PTEB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(write_addr) && $stable(write_data) && $stable(last), "stalled write word changed")

    // The only write that is not final is a coarse first-level descriptor.
    `PTEB_ASSERT_NOW(a_first_is_coarse, clk, rst_n, out_valid && !last, write_data[1:0] == pteb_pkg::DESC_COARSE, "non-final write is not a coarse descriptor")

    // Final writes are always section or small page descriptors.
    `PTEB_ASSERT_NOW(a_last_code, clk, rst_n, out_valid && last, write_data[1:0] == pteb_pkg::DESC_SECTION, "final write has a wrong descriptor type")

    // A coarse descriptor is followed at once by the small page write.
    `PTEB_ASSERT_NEXT(a_pair, clk, rst_n, out_valid && out_ready && !last, out_valid && last, "small page write did not follow its coarse descriptor")

endmodule

bind page_table_entry_builder pteb_checker u_checker (.*);
